>>> rtl/multitouch_slot_event_generator_top_assert.svh
// Assertion macros for the multitouch slot event generator.
`ifndef MULTITOUCH_SLOT_EVENT_GENERATOR_TOP_ASSERT_SVH
`define MULTITOUCH_SLOT_EVENT_GENERATOR_TOP_ASSERT_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define MSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define MSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mse_pkg.sv
// Package: codes, constants and types shared by the slot event generator.
`timescale 1ns / 1ps

package mse_pkg;

  localparam int NUM_SLOTS_DEF = 10;
  localparam int QUEUE_DEPTH   = 2;

  // commands
  localparam logic [1:0] OP_DOWN   = 2'd0;
  localparam logic [1:0] OP_CHANGE = 2'd1;
  localparam logic [1:0] OP_UP     = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSLOT  = 2'd1;
  localparam logic [1:0] ST_NOTDOWN = 2'd2;

  // event types
  localparam logic [1:0] T_SYN = 2'd0;
  localparam logic [1:0] T_KEY = 2'd1;
  localparam logic [1:0] T_ABS = 2'd3;

  // event codes
  localparam logic [8:0] C_SLOT   = 9'd47;
  localparam logic [8:0] C_MAJOR  = 9'd48;
  localparam logic [8:0] C_MINOR  = 9'd49;
  localparam logic [8:0] C_POSX   = 9'd53;
  localparam logic [8:0] C_POSY   = 9'd54;
  localparam logic [8:0] C_TRACK  = 9'd57;
  localparam logic [8:0] C_PRESS  = 9'd58;
  localparam logic [8:0] C_TOUCH  = 9'd330;
  localparam logic [8:0] C_FINGER = 9'd325;
  localparam logic [8:0] C_REPORT = 9'd0;

  localparam logic signed [16:0] VAL_RELEASE = -17'sd1;

  // word positions in emission order; a job carries one bit per word
  localparam int EV_SLOT   = 0;
  localparam int EV_TRACK  = 1;
  localparam int EV_POSX   = 2;
  localparam int EV_POSY   = 3;
  localparam int EV_MAJOR  = 4;
  localparam int EV_MINOR  = 5;
  localparam int EV_PRESS  = 6;
  localparam int EV_TOUCH  = 7;
  localparam int EV_FINGER = 8;
  localparam int EV_SYNC   = 9;
  localparam int EV_STATUS = 10;
  localparam int EV_N      = 11;
  localparam int EV_IDX_W  = $clog2(EV_N);

  typedef struct packed {
    logic [EV_N-1:0] mask;
    logic [3:0]      slot;
    logic [1:0]      status;
    logic            up;
    logic [15:0]     id;
    logic [14:0]     x;
    logic [14:0]     y;
    logic [7:0]      major;
    logic [7:0]      minor;
    logic [15:0]     press;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/multitouch_slot_event_generator_top.sv
// The first word of an accepted command passes through the job queue, the back end's job register
// and the single output register. Throughput: one output word per cycle while jobs are queued and
// out_ready is high; a command emits 1 to 11 words (a down command with pressure emits 11).
// A 2-deep job queue lets commands be accepted while earlier ones are still streaming.
// Reset (rst, synchronous): all slots free, tracking id counter at 1, queue and output empty.
`timescale 1ns / 1ps

module multitouch_slot_event_generator_top #(
  parameter int NUM_SLOTS = mse_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [3:0]          slot,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic [7:0]          size_major,
  input  logic [7:0]          size_minor,
  input  logic [15:0]         pressure,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                is_status,
  output logic [1:0]          ev_type,
  output logic [8:0]          ev_code,
  output logic signed [16:0]  ev_value,
  output logic [1:0]          status,
  output logic [3:0]          slot_out,
  output logic                last
);

  `include "multitouch_slot_event_generator_top_assert.svh"

  mse_pkg::q_stat_t q_stat;
  mse_pkg::job_t    push_job, head;
  logic             push, pop;

  mse_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .slot       (slot),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .size_major (size_major),
    .size_minor (size_minor),
    .pressure   (pressure),
    .q_stat     (q_stat),
    .push       (push),
    .job        (push_job)
  );

  mse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  mse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_status (is_status),
    .ev_type   (ev_type),
    .ev_code   (ev_code),
    .ev_value  (ev_value),
    .status    (status),
    .slot_out  (slot_out),
    .last      (last)
  );

  // a command streams without gaps until its status word
  `MSE_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !last, out_valid, "gap inside a command")
  `MSE_ASSERT_NOW(a_status_word, out_valid && is_status,
                  last && ev_type == mse_pkg::T_SYN && ev_code == mse_pkg::C_REPORT
                  && ev_value == 17'sd0, "malformed status word")
  `MSE_ASSERT_NOW(a_event_word, out_valid && !is_status,
                  !last && status == mse_pkg::ST_DONE, "malformed event word")

endmodule

>>> rtl/mse_front.sv
// Front end: slot table, command classification and job building.
`timescale 1ns / 1ps

module mse_front #(
  parameter int NUM_SLOTS = mse_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [3:0]          slot,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic [7:0]          size_major,
  input  logic [7:0]          size_minor,
  input  logic [15:0]         pressure,
  input  mse_pkg::q_stat_t    q_stat,
  output logic                push,
  output mse_pkg::job_t       job
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [NUM_SLOTS-1:0] slot_active;
  logic [14:0]          slot_pos_x    [NUM_SLOTS];
  logic [14:0]          slot_pos_y    [NUM_SLOTS];
  logic [7:0]           slot_major    [NUM_SLOTS];
  logic [7:0]           slot_minor    [NUM_SLOTS];
  logic [15:0]          slot_pressure [NUM_SLOTS];
  logic [15:0]          id_counter;

  logic [7:0]       maj, mnr;
  logic [14:0]      x_new, y_new;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] sidx;
  logic             in_range;
  logic             chg_x, chg_y, chg_maj, chg_mnr, chg_press;
  logic             do_down, do_change, do_up;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;
  assign sidx     = slot[IDX_W-1:0];

  always_comb begin
    maj = (size_major < size_minor) ? size_minor : size_major;
    mnr = (size_major < size_minor) ? size_major : size_minor;
    x_new = pos_x[15] ? 15'd0 : pos_x[14:0];
    y_new = pos_y[15] ? 15'd0 : pos_y[14:0];
    in_range = ({28'd0, slot} < 32'(NUM_SLOTS));

    // lowest free slot
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end

    chg_x     = !pos_x[15] && (pos_x[14:0] != slot_pos_x[sidx]);
    chg_y     = !pos_y[15] && (pos_y[14:0] != slot_pos_y[sidx]);
    chg_maj   = (maj != 8'd0) && (maj != slot_major[sidx]);
    chg_mnr   = (mnr != 8'd0) && (mnr != slot_minor[sidx]);
    chg_press = (pressure != 16'd0) && (pressure != slot_pressure[sidx]);

    do_down   = 1'b0;
    do_change = 1'b0;
    do_up     = 1'b0;

    job        = '0;
    job.slot   = slot;
    job.status = mse_pkg::ST_DONE;
    job.id     = (id_counter == 16'd0) ? 16'd1 : id_counter;
    job.x      = x_new;
    job.y      = y_new;
    job.major  = maj;
    job.minor  = mnr;
    job.press  = pressure;
    job.mask[mse_pkg::EV_STATUS] = 1'b1;

    case (op)
      mse_pkg::OP_DOWN: begin
        if (free_found) begin
          do_down  = 1'b1;
          job.slot = 4'(free_idx);
          job.mask[mse_pkg::EV_SLOT]   = 1'b1;
          job.mask[mse_pkg::EV_TRACK]  = 1'b1;
          job.mask[mse_pkg::EV_POSX]   = 1'b1;
          job.mask[mse_pkg::EV_POSY]   = 1'b1;
          job.mask[mse_pkg::EV_MAJOR]  = 1'b1;
          job.mask[mse_pkg::EV_MINOR]  = 1'b1;
          job.mask[mse_pkg::EV_PRESS]  = (pressure != 16'd0);
          job.mask[mse_pkg::EV_TOUCH]  = 1'b1;
          job.mask[mse_pkg::EV_FINGER] = 1'b1;
          job.mask[mse_pkg::EV_SYNC]   = 1'b1;
        end else begin
          job.status = mse_pkg::ST_NOSLOT;
          job.slot   = 4'd0;
        end
      end
      mse_pkg::OP_CHANGE, mse_pkg::OP_UP: begin
        if (!in_range) begin
          job.status = mse_pkg::ST_NOSLOT;
        end else if (!slot_active[sidx]) begin
          job.status = mse_pkg::ST_NOTDOWN;
        end else if (op == mse_pkg::OP_CHANGE) begin
          do_change = 1'b1;
          job.x = pos_x[14:0];
          job.y = pos_y[14:0];
          job.mask[mse_pkg::EV_SLOT]  = 1'b1;
          job.mask[mse_pkg::EV_POSX]  = chg_x;
          job.mask[mse_pkg::EV_POSY]  = chg_y;
          job.mask[mse_pkg::EV_MAJOR] = chg_maj;
          job.mask[mse_pkg::EV_MINOR] = chg_mnr;
          job.mask[mse_pkg::EV_PRESS] = chg_press;
          job.mask[mse_pkg::EV_SYNC]  = 1'b1;
        end else begin
          do_up  = 1'b1;
          job.up = 1'b1;
          job.mask[mse_pkg::EV_SLOT]   = 1'b1;
          job.mask[mse_pkg::EV_TRACK]  = 1'b1;
          job.mask[mse_pkg::EV_TOUCH]  = 1'b1;
          job.mask[mse_pkg::EV_FINGER] = 1'b1;
          job.mask[mse_pkg::EV_SYNC]   = 1'b1;
        end
      end
      default: begin
        job.status = mse_pkg::ST_NOSLOT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
      id_counter  <= 16'd1;
    end else if (push) begin
      if (do_down) begin
        slot_active[free_idx] <= 1'b1;
        id_counter            <= id_counter + 16'd1;
      end
      if (do_up) begin
        slot_active[sidx] <= 1'b0;
      end
    end
  end

  // table payload, written only by accepted commands
  always_ff @(posedge clk) begin
    if (push && do_down) begin
      slot_pos_x[free_idx]    <= x_new;
      slot_pos_y[free_idx]    <= y_new;
      slot_major[free_idx]    <= maj;
      slot_minor[free_idx]    <= mnr;
      slot_pressure[free_idx] <= pressure;
    end
    if (push && do_change) begin
      if (chg_x) slot_pos_x[sidx] <= pos_x[14:0];
      if (chg_y) slot_pos_y[sidx] <= pos_y[14:0];
      if (chg_maj) slot_major[sidx] <= maj;
      if (chg_mnr) slot_minor[sidx] <= mnr;
      if (chg_press) slot_pressure[sidx] <= pressure;
    end
  end

endmodule

>>> rtl/mse_queue.sv
// Job queue between the front end and the event emitter.
`timescale 1ns / 1ps

module mse_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mse_pkg::job_t     push_job,
  input  logic              pop,
  output mse_pkg::job_t     head,
  output mse_pkg::q_stat_t  q_stat
);

  localparam int DEPTH = mse_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mse_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rd_ptr];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

>>> rtl/mse_back.sv
// Back end: walks a job's word mask and drives the output register.
`timescale 1ns / 1ps

module mse_back (
  input  logic                clk,
  input  logic                rst,
  input  mse_pkg::q_stat_t    q_stat,
  input  mse_pkg::job_t       head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                is_status,
  output logic [1:0]          ev_type,
  output logic [8:0]          ev_code,
  output logic signed [16:0]  ev_value,
  output logic [1:0]          status,
  output logic [3:0]          slot_out,
  output logic                last
);

  mse_pkg::job_t                 cur;
  logic [mse_pkg::EV_N-1:0]      rem;
  logic [mse_pkg::EV_N-1:0]      lowbit, rem_clear;
  logic [mse_pkg::EV_IDX_W-1:0]  idx;
  logic                          advance;

  logic                          is_status_next, last_next;
  logic [1:0]                    ev_type_next, status_next;
  logic [8:0]                    ev_code_next;
  logic signed [16:0]            ev_value_next;

  assign advance   = (rem != '0) && (!out_valid || out_ready);
  assign lowbit    = rem & (~rem + 1'b1);
  assign rem_clear = rem & ~lowbit;
  // next job loads on the edge that sends the last word of the current one
  assign pop = !q_stat.empty && ((rem == '0) || (advance && rem_clear == '0));

  always_comb begin
    idx = '0;
    for (int i = mse_pkg::EV_N - 1; i >= 0; i--) begin
      if (rem[i]) idx = mse_pkg::EV_IDX_W'(i);
    end

    is_status_next = 1'b0;
    last_next      = 1'b0;
    status_next    = mse_pkg::ST_DONE;
    ev_type_next   = mse_pkg::T_ABS;
    ev_code_next   = mse_pkg::C_REPORT;
    ev_value_next  = '0;
    case (idx)
      mse_pkg::EV_IDX_W'(mse_pkg::EV_SLOT): begin
        ev_code_next  = mse_pkg::C_SLOT;
        ev_value_next = 17'(cur.slot);
      end
      mse_pkg::EV_IDX_W'(mse_pkg::EV_TRACK): begin
        ev_code_next  = mse_pkg::C_TRACK;
        ev_value_next = cur.up ? mse_pkg::VAL_RELEASE : 17'(cur.id);
      end
      mse_pkg::EV_IDX_W'(mse_pkg::EV_POSX): begin
        ev_code_next  = mse_pkg::C_POSX;
        ev_value_next = 17'(cur.x);
      end
      mse_pkg::EV_IDX_W'(mse_pkg::EV_POSY): begin
        ev_code_next  = mse_pkg::C_POSY;
        ev_value_next = 17'(cur.y);
      end
      mse_pkg::EV_IDX_W'(mse_pkg::EV_MAJOR): begin
        ev_code_next  = mse_pkg::C_MAJOR;
        ev_value_next = 17'(cur.major);
      end
      mse_pkg::EV_IDX_W'(mse_pkg::EV_MINOR): begin
        ev_code_next  = mse_pkg::C_MINOR;
        ev_value_next = 17'(cur.minor);
      end
      mse_pkg::EV_IDX_W'(mse_pkg::EV_PRESS): begin
        ev_code_next  = mse_pkg::C_PRESS;
        ev_value_next = 17'(cur.press);
      end
      mse_pkg::EV_IDX_W'(mse_pkg::EV_TOUCH): begin
        ev_type_next  = mse_pkg::T_KEY;
        ev_code_next  = mse_pkg::C_TOUCH;
        ev_value_next = cur.up ? 17'sd0 : 17'sd1;
      end
      mse_pkg::EV_IDX_W'(mse_pkg::EV_FINGER): begin
        ev_type_next  = mse_pkg::T_KEY;
        ev_code_next  = mse_pkg::C_FINGER;
        ev_value_next = cur.up ? 17'sd0 : 17'sd1;
      end
      mse_pkg::EV_IDX_W'(mse_pkg::EV_SYNC): begin
        ev_type_next = mse_pkg::T_SYN;
      end
      mse_pkg::EV_IDX_W'(mse_pkg::EV_STATUS): begin
        ev_type_next   = mse_pkg::T_SYN;
        is_status_next = 1'b1;
        last_next      = 1'b1;
        status_next    = cur.status;
      end
      default: begin
        ev_type_next = mse_pkg::T_SYN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        rem <= head.mask;
      end else if (advance) begin
        rem <= rem_clear;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance) begin
      is_status <= is_status_next;
      ev_type   <= ev_type_next;
      ev_code   <= ev_code_next;
      ev_value  <= ev_value_next;
      status    <= status_next;
      slot_out  <= cur.slot;
      last      <= last_next;
    end
  end

endmodule

>>> tb/tb_multitouch_slot_event_generator_top.sv
// Testbench for the multitouch slot event generator: directed and random commands.
`timescale 1ns / 1ps

module tb_multitouch_slot_event_generator_top;

  localparam int NSLOT = mse_pkg::NUM_SLOTS_DEF;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         op;
  logic [3:0]         slot;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [7:0]         size_major;
  logic [7:0]         size_minor;
  logic [15:0]        pressure;
  logic               out_valid;
  logic               out_ready;
  logic               is_status;
  logic [1:0]         ev_type;
  logic [8:0]         ev_code;
  logic signed [16:0] ev_value;
  logic [1:0]         status;
  logic [3:0]         slot_out;
  logic               last;

  int idle_pct;
  int stall_pct;
  int hold_cycles;

  multitouch_slot_event_generator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .slot(slot), .pos_x(pos_x), .pos_y(pos_y),
    .size_major(size_major), .size_minor(size_minor), .pressure(pressure),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_status(is_status), .ev_type(ev_type), .ev_code(ev_code), .ev_value(ev_value),
    .status(status), .slot_out(slot_out), .last(last)
  );

  class touch_event_scoreboard;
    typedef struct {
      logic        is_st;
      logic [1:0]  ty;
      logic [8:0]  code;
      logic [16:0] val;
      logic [1:0]  st;
      logic [3:0]  sl;
      logic        lst;
    } event_word_t;

    event_word_t expected_words[$];
    bit          active[NSLOT];
    bit [14:0]   pos_x_tab[NSLOT];
    bit [14:0]   pos_y_tab[NSLOT];
    bit [7:0]    major_tab[NSLOT];
    bit [7:0]    minor_tab[NSLOT];
    bit [15:0]   press_tab[NSLOT];
    bit [15:0]   next_id;
    int          errors;

    function new();
      foreach (active[i]) begin
        active[i] = 1'b0;
        pos_x_tab[i] = '0;
        pos_y_tab[i] = '0;
        major_tab[i] = '0;
        minor_tab[i] = '0;
        press_tab[i] = '0;
      end
      next_id = 16'd1;
      errors = 0;
    endfunction

    function int lowest_free();
      for (int i = 0; i < NSLOT; i++)
        if (!active[i]) return i;
      return NSLOT;
    endfunction

    function void push_event(logic [1:0] ty, logic [8:0] code, int val, logic [3:0] sl);
      event_word_t w;
      w.is_st = 1'b0; w.ty = ty; w.code = code; w.val = val[16:0];
      w.st = '0; w.sl = sl; w.lst = 1'b0;
      expected_words = {expected_words, w};
    endfunction

    function void push_status(logic [1:0] st, logic [3:0] sl);
      event_word_t w;
      w.is_st = 1'b1; w.ty = '0; w.code = '0; w.val = '0;
      w.st = st; w.sl = sl; w.lst = 1'b1;
      expected_words = {expected_words, w};
    endfunction

    // accepted command: update the slot table and queue the words it must produce
    function void note_command(logic [1:0] c_op, logic [3:0] sl, logic signed [15:0] x,
                               logic signed [15:0] y, logic [7:0] maj, logic [7:0] mn,
                               logic [15:0] pr);
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [15:0] tid;
      int          s;
      hi = (maj < mn) ? mn : maj;
      lo = (maj < mn) ? maj : mn;
      if (c_op == mse_pkg::OP_DOWN) begin
        s = lowest_free();
        if (s == NSLOT) begin
          push_status(mse_pkg::ST_NOSLOT, '0);
          return;
        end
        if (x < 0) x = '0;
        if (y < 0) y = '0;
        tid = (next_id == 16'd0) ? 16'd1 : next_id;
        next_id++;
        active[s] = 1'b1;
        pos_x_tab[s] = x[14:0];
        pos_y_tab[s] = y[14:0];
        major_tab[s] = hi;
        minor_tab[s] = lo;
        press_tab[s] = pr;
        push_event(mse_pkg::T_ABS, mse_pkg::C_SLOT, s, 4'(s));
        push_event(mse_pkg::T_ABS, mse_pkg::C_TRACK, int'(tid), 4'(s));
        push_event(mse_pkg::T_ABS, mse_pkg::C_POSX, int'(x), 4'(s));
        push_event(mse_pkg::T_ABS, mse_pkg::C_POSY, int'(y), 4'(s));
        push_event(mse_pkg::T_ABS, mse_pkg::C_MAJOR, int'(hi), 4'(s));
        push_event(mse_pkg::T_ABS, mse_pkg::C_MINOR, int'(lo), 4'(s));
        if (pr != 0) push_event(mse_pkg::T_ABS, mse_pkg::C_PRESS, int'(pr), 4'(s));
        push_event(mse_pkg::T_KEY, mse_pkg::C_TOUCH, 1, 4'(s));
        push_event(mse_pkg::T_KEY, mse_pkg::C_FINGER, 1, 4'(s));
        push_event(mse_pkg::T_SYN, mse_pkg::C_REPORT, 0, 4'(s));
        push_status(mse_pkg::ST_DONE, 4'(s));
        return;
      end
      if ((c_op != mse_pkg::OP_CHANGE && c_op != mse_pkg::OP_UP) || sl >= NSLOT) begin
        push_status(mse_pkg::ST_NOSLOT, sl);
        return;
      end
      if (!active[sl]) begin
        push_status(mse_pkg::ST_NOTDOWN, sl);
        return;
      end
      push_event(mse_pkg::T_ABS, mse_pkg::C_SLOT, int'(sl), sl);
      if (c_op == mse_pkg::OP_CHANGE) begin
        if (x >= 0 && x[14:0] != pos_x_tab[sl]) begin
          pos_x_tab[sl] = x[14:0];
          push_event(mse_pkg::T_ABS, mse_pkg::C_POSX, int'(x), sl);
        end
        if (y >= 0 && y[14:0] != pos_y_tab[sl]) begin
          pos_y_tab[sl] = y[14:0];
          push_event(mse_pkg::T_ABS, mse_pkg::C_POSY, int'(y), sl);
        end
        if (hi != 0 && hi != major_tab[sl]) begin
          major_tab[sl] = hi;
          push_event(mse_pkg::T_ABS, mse_pkg::C_MAJOR, int'(hi), sl);
        end
        if (lo != 0 && lo != minor_tab[sl]) begin
          minor_tab[sl] = lo;
          push_event(mse_pkg::T_ABS, mse_pkg::C_MINOR, int'(lo), sl);
        end
        if (pr != 0 && pr != press_tab[sl]) begin
          press_tab[sl] = pr;
          push_event(mse_pkg::T_ABS, mse_pkg::C_PRESS, int'(pr), sl);
        end
      end else begin
        push_event(mse_pkg::T_ABS, mse_pkg::C_TRACK, int'(mse_pkg::VAL_RELEASE), sl);
        push_event(mse_pkg::T_KEY, mse_pkg::C_TOUCH, 0, sl);
        push_event(mse_pkg::T_KEY, mse_pkg::C_FINGER, 0, sl);
        active[sl] = 1'b0;
      end
      push_event(mse_pkg::T_SYN, mse_pkg::C_REPORT, 0, sl);
      push_status(mse_pkg::ST_DONE, sl);
    endfunction

    function void flag(string fld, logic [16:0] e, logic [16:0] a);
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, fld, e, a);
    endfunction

    function void check_word(logic is_st, logic [1:0] ty, logic [8:0] code, logic [16:0] val,
                             logic [1:0] st, logic [3:0] sl, logic lst);
      event_word_t w;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, got st %b type %h code %h value %h",
                 $time, is_st, ty, code, val);
        return;
      end
      w = expected_words.pop_front();
      if (is_st !== w.is_st) flag("is_status", w.is_st, is_st);
      if (ty !== w.ty)       flag("ev_type", w.ty, ty);
      if (code !== w.code)   flag("ev_code", w.code, code);
      if (val !== w.val)     flag("ev_value", w.val, val);
      if (st !== w.st)       flag("status", w.st, st);
      if (sl !== w.sl)       flag("slot_out", w.sl, sl);
      if (lst !== w.lst)     flag("last", w.lst, lst);
    endfunction
  endclass

  touch_event_scoreboard sb;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_cmd(input logic [1:0] c_op, input logic [3:0] c_sl,
                          input logic signed [15:0] c_x, input logic signed [15:0] c_y,
                          input logic [7:0] c_maj, input logic [7:0] c_min,
                          input logic [15:0] c_press);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    op = c_op;
    slot = c_sl;
    pos_x = c_x;
    pos_y = c_y;
    size_major = c_maj;
    size_minor = c_min;
    pressure = c_press;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(c_op, c_sl, c_x, c_y, c_maj, c_min, c_press);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_coord(logic [14:0] cur);
    int r;
    r = $urandom_range(99);
    if (r < 25) return -16'sd1;
    if (r < 40) return {1'b0, cur};
    if (r < 50) return 16'($urandom);
    if (r < 55) return 16'sd32767;
    return 16'($urandom_range(32767));
  endfunction

  function automatic logic [7:0] pick_byte(logic [7:0] cur);
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'd0;
    if (r < 45) return cur;
    if (r < 55) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] pick_press(logic [15:0] cur);
    int r;
    r = $urandom_range(99);
    if (r < 30) return 16'd0;
    if (r < 45) return cur;
    if (r < 55) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [3:0] pick_active();
    int act[$];
    for (int i = 0; i < NSLOT; i++)
      if (sb.active[i]) act = {act, i};
    if (act.size() == 0) return 4'($urandom_range(15));
    return 4'(act[$urandom_range(act.size() - 1)]);
  endfunction

  // downs, plus changes and releases on live slots, some noise on bad ops and slots
  task automatic random_command();
    int         r;
    logic [1:0] c_op;
    logic [3:0] c_sl;
    logic [14:0] cx, cy;
    logic [7:0]  cmaj, cmin;
    logic [15:0] cp;
    r = $urandom_range(99);
    if (r < 5) begin
      c_op = 2'($urandom_range(3));
      c_sl = 4'($urandom_range(15));
    end else if (r < 40) begin
      c_op = mse_pkg::OP_DOWN;
      c_sl = 4'($urandom);
    end else if (r < 75) begin
      c_op = mse_pkg::OP_CHANGE;
      c_sl = pick_active();
    end else begin
      c_op = mse_pkg::OP_UP;
      c_sl = pick_active();
    end
    if (c_sl < NSLOT && c_op != mse_pkg::OP_DOWN) begin
      cx = sb.pos_x_tab[c_sl];
      cy = sb.pos_y_tab[c_sl];
      cmaj = sb.major_tab[c_sl];
      cmin = sb.minor_tab[c_sl];
      cp = sb.press_tab[c_sl];
    end else begin
      cx = 15'($urandom);
      cy = 15'($urandom);
      cmaj = 8'($urandom);
      cmin = 8'($urandom);
      cp = 16'($urandom);
    end
    send_cmd(c_op, c_sl, pick_coord(cx), pick_coord(cy), pick_byte(cmaj), pick_byte(cmin),
             pick_press(cp));
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word(is_status, ev_type, ev_code, ev_value, status, slot_out, last);
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    op = mse_pkg::OP_DOWN;
    slot = '0;
    pos_x = '0;
    pos_y = '0;
    size_major = '0;
    size_minor = '0;
    pressure = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: error paths on an empty table, extreme downs, change filtering, a full table, releases
    send_cmd(mse_pkg::OP_CHANGE, 4'd0, 16'sd5, 16'sd5, 8'd1, 8'd1, 16'd1);
    send_cmd(mse_pkg::OP_UP, 4'd15, -16'sd1, -16'sd1, 8'd0, 8'd0, 16'd0);
    send_cmd(OP_UNDEF, 4'd5, 16'sd1, 16'sd1, 8'd1, 8'd1, 16'd1);
    send_cmd(mse_pkg::OP_DOWN, 4'd15, -16'sd1, -16'sd32768, 8'd3, 8'd200, 16'd0);
    send_cmd(mse_pkg::OP_DOWN, 4'd0, 16'sd32767, 16'sd32767, 8'd255, 8'd0, 16'hFFFF);
    send_cmd(mse_pkg::OP_DOWN, 4'd7, 16'sd0, 16'sd1, 8'd0, 8'd0, 16'd1);
    send_cmd(mse_pkg::OP_CHANGE, 4'd0, -16'sd1, -16'sd1, 8'd0, 8'd0, 16'd0);
    send_cmd(mse_pkg::OP_CHANGE, 4'd1, 16'sd32767, 16'sd32767, 8'd255, 8'd0, 16'hFFFF);
    send_cmd(mse_pkg::OP_CHANGE, 4'd2, 16'sd12345, -16'sd1, 8'd10, 8'd20, 16'd500);
    send_cmd(mse_pkg::OP_CHANGE, 4'd2, -16'sd32768, 16'sd0, 8'd20, 8'd0, 16'd500);
    repeat (7) send_cmd(mse_pkg::OP_DOWN, 4'($urandom), 16'($urandom_range(32767)),
                        16'($urandom_range(32767)), 8'($urandom), 8'($urandom),
                        16'($urandom));
    send_cmd(mse_pkg::OP_DOWN, 4'd3, 16'sd100, 16'sd100, 8'd9, 8'd9, 16'd9);
    send_cmd(mse_pkg::OP_UP, 4'd4, -16'sd1, -16'sd1, 8'd0, 8'd0, 16'd0);
    send_cmd(mse_pkg::OP_UP, 4'd4, -16'sd1, -16'sd1, 8'd0, 8'd0, 16'd0);
    send_cmd(mse_pkg::OP_CHANGE, 4'd4, 16'sd1, 16'sd1, 8'd1, 8'd1, 16'd1);
    send_cmd(mse_pkg::OP_DOWN, 4'd0, 16'sd200, 16'sd300, 8'd40, 8'd30, 16'd0);
    send_cmd(mse_pkg::OP_CHANGE, 4'd10, 16'sd1, 16'sd1, 8'd1, 8'd1, 16'd1);
    send_cmd(mse_pkg::OP_UP, 4'd9, -16'sd1, -16'sd1, 8'd0, 8'd0, 16'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          hold_cycles = 300;
        end
        1: begin
          idle_pct = 83;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 83;
        end
        default: begin
          idle_pct = 22;
          stall_pct = 22;
        end
      endcase
      repeat (59) random_command();
    end
    in_valid = 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> multitouch_slot_event_generator_top.f
+incdir+rtl
rtl/mse_pkg.sv
rtl/mse_front.sv
rtl/mse_queue.sv
rtl/mse_back.sv
rtl/multitouch_slot_event_generator_top.sv
tb/tb_multitouch_slot_event_generator_top.sv
